@@ design/sldst_pkg.sv @@
// shared types, codes and mode decode for the scan line and display start block
`timescale 1ns / 1ps
package sldst_pkg;

  localparam int MAX_OFFSET_DEF = 1023;
  localparam int DVD_W = 36;
  localparam int DSR_W = 16;

  localparam logic [2:0] ACT_SET_PIX   = 3'd0;
  localparam logic [2:0] ACT_GET_LEN   = 3'd1;
  localparam logic [2:0] ACT_SET_BYTES = 3'd2;
  localparam logic [2:0] ACT_GET_MAX   = 3'd3;
  localparam logic [2:0] ACT_SET_START = 3'd4;
  localparam logic [2:0] ACT_GET_START = 3'd5;
  localparam logic [2:0] ACT_RAW_START = 3'd6;
  localparam logic [2:0] ACT_OTHER     = 3'd7;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FAIL   = 3'd1;
  localparam logic [2:0] ST_HW_UNS = 3'd2;
  localparam logic [2:0] ST_MODE_UNS = 3'd3;
  localparam logic [2:0] ST_UNIMPL = 3'd4;

  localparam logic [2:0] MODE_TEXT    = 3'd0;
  localparam logic [2:0] MODE_PLANAR4 = 3'd1;
  localparam logic [2:0] MODE_LIN8    = 3'd2;
  localparam logic [2:0] MODE_LIN15   = 3'd3;
  localparam logic [2:0] MODE_LIN16   = 3'd4;
  localparam logic [2:0] MODE_LIN32   = 3'd5;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_VMEM   = 3'd1;
  localparam logic [2:0] REG_GHEIGHT = 3'd2;
  localparam logic [2:0] REG_ROWS   = 3'd3;
  localparam logic [2:0] REG_CHAR_H = 3'd4;

  localparam logic [24:0] TEXT_WINDOW = 25'h0008000;

  typedef struct packed {
    logic             ok;
    logic [2:0]       ppc_sh;   // log2 pixels per cell
    logic [1:0]       bpc_sh;   // log2 bytes per cell
    logic             pf2;      // pan factor of two
  } cells_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
    logic [DSR_W-1:0] remainder;
  } div_rsp_t;

  function automatic cells_t mode_cells(input logic [2:0] mode);
    cells_t c;
    c = '{ok: 1'b1, ppc_sh: 3'd3, bpc_sh: 2'd3, pf2: 1'b0};
    case (mode)
      MODE_TEXT:    begin c.ppc_sh = 3'd4; c.bpc_sh = 2'd2; end
      MODE_PLANAR4: begin c.ppc_sh = 3'd4; end
      MODE_LIN8:    begin c.ppc_sh = 3'd3; c.pf2 = 1'b1; end
      MODE_LIN15,
      MODE_LIN16:   begin c.ppc_sh = 3'd2; c.pf2 = 1'b1; end
      MODE_LIN32:   begin c.ppc_sh = 3'd1; end
      default:      c.ok = 1'b0;
    endcase
    return c;
  endfunction

endpackage

@@ design/scan_line_and_display_start_top.sv @@
// scan line length and display start controller, top level
`timescale 1ns / 1ps
// Requests arrive on the in_ stream: in_tuser carries the action, in_tdata the
// length, start column/row and raw start word. Every request gives one result
// word on the out_ stream with the status in out_tuser.
// Mode settings are written through the cfg_ channel (index, data), always
// ready; writes are expected only while no request is in flight.
// Requests that need no division go straight to the result. Setting or
// reading the length and reading the maximum run the shared bit-serial
// divider once, reading the maximum may run it twice and reading the start
// back runs it once. The divider retires one quotient bit per cycle over a
// 36-bit dividend. One request is in work at a time.
// Reset (rst_n low, synchronous) restores the mode registers to their
// defaults and clears line offset, start word and pan value.
// A finished result sits in the output register; while the receiver stalls,
// the next request may be taken and computed, then waits until the output
// register is free.
module scan_line_and_display_start_top import sldst_pkg::*; #(
  parameter int MAX_LINE_OFFSET = MAX_OFFSET_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // length_value, start_x, start_y, raw_start
  input  logic [2:0]  in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // line_bytes, line_pixels, line_count, out_x, out_y
  output logic [2:0]  out_tuser,  // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [24:0] cfg_data
);

  localparam int OW = $clog2(MAX_LINE_OFFSET + 1);
  localparam int MW = (OW + 16 > 25) ? OW + 16 : 25;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_DMAX  = 3'd2;
  localparam logic [2:0] S_LEN   = 3'd3;
  localparam logic [2:0] S_DLINE = 3'd4;
  localparam logic [2:0] S_DPOS  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]  state_r, state_nxt;

  logic [2:0]  mode_r;
  logic [24:0] vmem_r;
  logic [12:0] gheight_r;
  logic [7:0]  rows_r;
  logic [5:0]  char_h_r;

  logic [9:0]  line_off_r;
  logic [31:0] start_word_r;
  logic [7:0]  pan_r;

  logic [2:0]  act_r;
  logic [15:0] len_r, sx_r, sy_r;
  logic [31:0] raw_r;
  logic [OW-1:0] off_r;

  logic [2:0]  res_status_r;
  logic [15:0] res_bytes_r, res_pix_r, res_lines_r, res_x_r, res_y_r;

  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [79:0] out_data_r;

  logic             dstart_r;
  logic [DVD_W-1:0] ddvd_r;
  logic [DSR_W-1:0] ddsr_r;
  div_req_t    dreq;
  div_rsp_t    drsp;

  cells_t      cells;
  logic        text;
  logic [24:0] mem;
  logic [12:0] height;
  logic [15:0] bpch;
  logic [MW-1:0] max_need;
  logic [3:0]  unit_m1;
  logic [16:0] len_sum;
  logic [16:0] off_set;
  logic [25:0] lo_y;
  logic [30:0] pixel_set;
  logic [2:0]  half_sh;
  logic [2:0]  half_mask;
  logic [31:0] off_ext;
  logic [15:0] bytes_w, pix_w;
  logic [13:0] width_w;
  logic [35:0] pixel_get;
  logic [21:0] lines_mul;
  logic        out_free;

  assign dreq.start    = dstart_r;
  assign dreq.dividend = ddvd_r;
  assign dreq.divisor  = ddsr_r;

  sldst_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  assign cells    = mode_cells(mode_r);
  assign text     = (mode_r == MODE_TEXT);
  assign mem      = text ? TEXT_WINDOW : vmem_r;
  assign height   = text ? {5'd0, rows_r} : gheight_r;
  assign bpch     = {3'd0, height} << cells.bpc_sh;
  assign max_need = MW'(MAX_LINE_OFFSET) * MW'(bpch);

  // round up to whole offset cells
  assign unit_m1  = (act_r == ACT_SET_PIX) ? (4'((5'd1 << cells.ppc_sh) - 5'd1))
                                           : (4'((5'd1 << cells.bpc_sh) - 5'd1));
  assign len_sum  = {1'b0, len_r} + {13'd0, unit_m1};
  assign off_set  = len_sum >> ((act_r == ACT_SET_PIX) ? cells.ppc_sh : {1'b0, cells.bpc_sh});

  assign lo_y      = line_off_r * sy_r;
  assign pixel_set = ({5'd0, lo_y} << cells.ppc_sh) + {15'd0, sx_r};
  assign half_sh   = cells.ppc_sh - 3'd1;
  assign half_mask = 3'((4'd1 << half_sh) - 4'd1);

  assign off_ext = 32'(off_r);
  assign bytes_w = 16'(off_ext << cells.bpc_sh);
  assign pix_w   = 16'(off_ext << cells.ppc_sh);

  assign width_w   = {4'd0, line_off_r} << cells.ppc_sh;
  assign pixel_get = ({4'd0, start_word_r} << half_sh)
                   + {28'd0, (cells.pf2 ? {1'b0, pan_r[7:1]} : pan_r)};
  assign lines_mul = drsp.quotient[15:0] * char_h_r;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_EVAL;
      S_EVAL: begin
        state_nxt = S_DONE;
        if (act_r != ACT_RAW_START && act_r != ACT_OTHER && cells.ok) begin
          if (act_r == ACT_SET_PIX || act_r == ACT_SET_BYTES) begin
            if (off_set <= 17'(MAX_LINE_OFFSET)) state_nxt = S_LEN;
          end else if (act_r == ACT_GET_LEN) begin
            state_nxt = S_LEN;
          end else if (act_r == ACT_GET_MAX) begin
            state_nxt = (max_need > MW'(mem)) ? S_DMAX : S_LEN;
          end else if (act_r == ACT_GET_START) begin
            if (width_w != '0) state_nxt = S_DPOS;
          end
        end
      end
      S_DMAX:  if (drsp.done) state_nxt = S_LEN;
      S_LEN:   state_nxt = (bytes_w == '0) ? S_DONE : S_DLINE;
      S_DLINE: if (drsp.done) state_nxt = S_DONE;
      S_DPOS:  if (drsp.done) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_r       <= MODE_LIN8;
      vmem_r       <= 25'd2097152;
      gheight_r    <= 13'd480;
      rows_r       <= 8'd25;
      char_h_r     <= 6'd16;
      line_off_r   <= '0;
      start_word_r <= '0;
      pan_r        <= '0;
      out_valid_r  <= 1'b0;
      dstart_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      dstart_r     <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          REG_MODE:    mode_r    <= cfg_data[2:0];
          REG_VMEM:    vmem_r    <= cfg_data;
          REG_GHEIGHT: gheight_r <= cfg_data[12:0];
          REG_ROWS:    rows_r    <= cfg_data[7:0];
          REG_CHAR_H:  char_h_r  <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (state_r == S_EVAL) begin
        if (act_r == ACT_RAW_START) begin
          start_word_r <= raw_r;
        end else if (cells.ok) begin
          if ((act_r == ACT_SET_PIX || act_r == ACT_SET_BYTES)
              && off_set <= 17'(MAX_LINE_OFFSET)) begin
            line_off_r <= off_set[9:0];
          end else if (act_r == ACT_GET_MAX && max_need > MW'(mem)) begin
            dstart_r <= 1'b1;
          end else if (act_r == ACT_SET_START) begin
            start_word_r <= 32'(pixel_set >> half_sh);
            pan_r        <= 8'({5'd0, pixel_set[2:0] & half_mask} << cells.pf2);
          end else if (act_r == ACT_GET_START && width_w != '0) begin
            dstart_r <= 1'b1;
          end
        end
      end
      if (state_r == S_LEN && bytes_w != '0) dstart_r <= 1'b1;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request, working and result words
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      act_r <= in_tuser;
      len_r <= in_tdata[15:0];
      sx_r  <= in_tdata[31:16];
      sy_r  <= in_tdata[47:32];
      raw_r <= in_tdata[79:48];
    end
    case (state_r)
      S_EVAL: begin
        res_bytes_r <= '0;
        res_pix_r   <= '0;
        res_lines_r <= '0;
        res_x_r     <= '0;
        res_y_r     <= '0;
        res_status_r <= ST_OK;
        off_r        <= OW'(MAX_LINE_OFFSET);
        ddvd_r       <= {11'd0, mem};
        ddsr_r       <= bpch;
        if (act_r == ACT_OTHER) begin
          res_status_r <= ST_UNIMPL;
        end else if (act_r != ACT_RAW_START) begin
          if (!cells.ok) begin
            res_status_r <= ST_MODE_UNS;
          end else if (act_r == ACT_SET_PIX || act_r == ACT_SET_BYTES) begin
            if (off_set > 17'(MAX_LINE_OFFSET)) res_status_r <= ST_HW_UNS;
            off_r <= OW'(off_set);
          end else if (act_r == ACT_GET_LEN) begin
            off_r <= OW'(line_off_r);
          end else if (act_r == ACT_GET_START) begin
            if (width_w == '0) res_status_r <= ST_FAIL;
            ddvd_r <= pixel_get;
            ddsr_r <= {2'd0, width_w};
          end
        end
      end
      S_DMAX: if (drsp.done) off_r <= OW'(drsp.quotient);
      S_LEN: begin
        res_bytes_r <= bytes_w;
        res_pix_r   <= pix_w;
        if (bytes_w == '0) res_status_r <= ST_FAIL;
        ddvd_r <= {11'd0, mem};
        ddsr_r <= bytes_w;
      end
      S_DLINE: if (drsp.done) begin
        res_lines_r <= text ? lines_mul[15:0] : drsp.quotient[15:0];
      end
      S_DPOS: if (drsp.done) begin
        res_x_r <= drsp.remainder;
        res_y_r <= drsp.quotient[15:0];
      end
      default: ;
    endcase
    if (state_r == S_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_data_r   <= {res_y_r, res_x_r, res_lines_r, res_pix_r, res_bytes_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = out_data_r;

endmodule

@@ design/sldst_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module sldst_div import sldst_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] quo_r;
  logic [DSR_W-1:0] rem_r;
  logic [DSR_W-1:0] dsr_r;
  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign ge    = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      dsr_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], ge};
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule
